>>> hw/rtl/inode_dir_allocator_top_assert.svh
// Assertion macros shared by the inode/directory allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef INODE_DIR_ALLOCATOR_TOP_ASSERT_SVH
`define INODE_DIR_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IDA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/idalloc_pkg.sv
// Types, sizes, codes and helper functions of the inode/directory allocator.
// No dependencies; imported by every module of the block.
package idalloc_pkg;

  localparam int INODE_COUNT = 8;
  localparam int BLOCK_COUNT = 8;
  localparam int DIR_SLOTS   = 4;
  localparam int NAME_BYTES  = 8;
  localparam int USER_SLOTS  = DIR_SLOTS - 2;

  localparam int INO_W  = $clog2(INODE_COUNT);
  localparam int BLK_W  = $clog2(BLOCK_COUNT);
  localparam int SLOT_W = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int SCAN_W = (INO_W > BLK_W) ?
                          ((INO_W > SLOT_W) ? INO_W : SLOT_W) :
                          ((BLK_W > SLOT_W) ? BLK_W : SLOT_W);

  localparam int NAME_W = 64;
  localparam int CNT_W  = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [NAME_W-1:0] NAME_DOT    = 64'h2E;
  localparam logic [NAME_W-1:0] NAME_DOTDOT = 64'h2E2E;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_MKDIR  = 2'd1,
    CMD_WRITE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NO_INODE  = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_NOT_FILE  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_FILE = 2'd1,
    KIND_DIR  = 2'd2
  } kind_t;

  // Test performed by the shared probe unit at the current scan index
  typedef enum logic [1:0] {
    PR_SLOT_MATCH = 2'd0,
    PR_INODE_FREE = 2'd1,
    PR_BLOCK_FREE = 2'd2,
    PR_SLOT_FREE  = 2'd3
  } probe_t;

  typedef struct packed {
    probe_t              mode;
    logic [SCAN_W-1:0]   idx;
  } probe_req_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [NAME_W-1:0] entry_name;
    logic [7:0]        file_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       inode_number;
    logic [CNT_W-1:0] files_made;
    logic [CNT_W-1:0] dirs_made;
  } out_item_t;

  // Keep bytes up to the first zero byte, at most NAME_BYTES-1 of them.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int i = 0; i < NAME_BYTES - 1; i++) begin
      if (raw[8*i +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> hw/rtl/idalloc_probe.sv
// Shared probe unit: one name compare or one bitmap/slot test per cycle.
// Depends on idalloc_pkg.
module idalloc_probe import idalloc_pkg::*; (
  input  probe_req_t                         req,
  input  logic [NAME_W-1:0]                  name,
  input  logic [USER_SLOTS-1:0][NAME_W-1:0]  slot_names,
  input  logic [INODE_COUNT-1:0]             inode_busy,
  input  logic [BLOCK_COUNT-1:0]             block_busy,
  output logic                               hit
);

  logic [NAME_W-1:0] slot_sel;

  assign slot_sel = slot_names[req.idx[SLOT_W-1:0]];

  always_comb begin
    case (req.mode)
      PR_SLOT_MATCH: hit = (slot_sel == name);
      PR_INODE_FREE: hit = !inode_busy[req.idx[INO_W-1:0]];
      PR_BLOCK_FREE: hit = !block_busy[req.idx[BLK_W-1:0]];
      PR_SLOT_FREE:  hit = (slot_sel[7:0] == 8'h00);
      default:       hit = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/inode_dir_allocator_top.sv
// Top level of the inode/directory allocator: command sequencer and metadata state.
// Depends on idalloc_pkg, idalloc_probe and inode_dir_allocator_top_assert.svh.
//
//   channel | signals                         | beat
//   --------+---------------------------------+-------------------------------------
//   in      | in_valid, in_ready, in_data     | command, entry_name, file_byte
//   out     | out_valid, out_ready, out_data  | status, inode_number, files_made,
//           |                                 | dirs_made
//
// One command is worked at a time; in_ready is high only while the sequencer waits.
// The probe unit tests one slot, inode or block per cycle (lookup up to 2 slots,
// inode scan up to 8, block scan up to 8, free-slot scan up to 2), plus accept,
// decide, commit and result-load steps.
// The result register lets the next command be taken while a result still waits;
// a finished command holds in its result state while that register stays full.
// Reset (rst_n low, synchronous) restores the empty root directory; no clearing pass.
`include "inode_dir_allocator_top_assert.svh"

module inode_dir_allocator_top import idalloc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_INODE,
    S_BLOCK,
    S_SLOT,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t                             state_r, state_nxt;
  logic [1:0]                         cmd_r, cmd_nxt;
  logic [NAME_W-1:0]                  name_r, name_nxt;
  logic [7:0]                         byte_r, byte_nxt;
  logic [SCAN_W-1:0]                  idx_r, idx_nxt;
  logic                               found_r, found_nxt;
  logic [INO_W-1:0]                   fino_r, fino_nxt;
  logic [INO_W-1:0]                   ni_r, ni_nxt;
  logic [BLK_W-1:0]                   blk_r, blk_nxt;
  logic [SLOT_W-1:0]                  sl_r, sl_nxt;
  logic [2:0]                         stat_r, stat_nxt;
  logic [INO_W-1:0]                   res_ino_r, res_ino_nxt;

  logic [INODE_COUNT-1:0]             inode_busy_r, inode_busy_nxt;
  logic [INODE_COUNT-1:0][1:0]        kind_r, kind_nxt;
  logic [INODE_COUNT-1:0][BLK_W-1:0]  iblk_r, iblk_nxt;
  logic [INODE_COUNT-1:0]             has_blk_r, has_blk_nxt;
  logic [BLOCK_COUNT-1:0]             block_busy_r, block_busy_nxt;
  logic [USER_SLOTS-1:0][NAME_W-1:0]  slot_name_r, slot_name_nxt;
  logic [USER_SLOTS-1:0][INO_W-1:0]   slot_ino_r, slot_ino_nxt;
  logic [CNT_W-1:0]                   root_links_r, root_links_nxt;
  logic [CNT_W-1:0]                   file_total_r, file_total_nxt;
  logic [CNT_W-1:0]                   dir_total_r, dir_total_nxt;

  logic                               out_valid_r, out_valid_nxt;
  out_item_t                          out_r, out_nxt;

  logic [7:0]                         stored_mem [BLOCK_COUNT];
  logic                               mem_we;

  probe_req_t                         probe_req;
  logic                               probe_hit;
  logic [NAME_W-1:0]                  in_name;
  logic                               cmd_valid;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_name   = norm_name(in_data.entry_name);
  assign cmd_valid = (in_data.command == CMD_CREATE) || (in_data.command == CMD_MKDIR) ||
                     (in_data.command == CMD_WRITE);

  always_comb begin
    probe_req.idx = idx_r;
    case (state_r)
      S_LOOK:  probe_req.mode = PR_SLOT_MATCH;
      S_INODE: probe_req.mode = PR_INODE_FREE;
      S_BLOCK: probe_req.mode = PR_BLOCK_FREE;
      default: probe_req.mode = PR_SLOT_FREE;
    endcase
  end

  idalloc_probe u_probe (
    .req        (probe_req),
    .name       (name_r),
    .slot_names (slot_name_r),
    .inode_busy (inode_busy_r),
    .block_busy (block_busy_r),
    .hit        (probe_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    name_nxt       = name_r;
    byte_nxt       = byte_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    fino_nxt       = fino_r;
    ni_nxt         = ni_r;
    blk_nxt        = blk_r;
    sl_nxt         = sl_r;
    stat_nxt       = stat_r;
    res_ino_nxt    = res_ino_r;
    inode_busy_nxt = inode_busy_r;
    kind_nxt       = kind_r;
    iblk_nxt       = iblk_r;
    has_blk_nxt    = has_blk_r;
    block_busy_nxt = block_busy_r;
    slot_name_nxt  = slot_name_r;
    slot_ino_nxt   = slot_ino_r;
    root_links_nxt = root_links_r;
    file_total_nxt = file_total_r;
    dir_total_nxt  = dir_total_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    // Drop the result once taken; a new load below overrides this
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data.command;
          name_nxt    = in_name;
          byte_nxt    = in_data.file_byte;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          fino_nxt    = '0;
          res_ino_nxt = '0;
          if (!cmd_valid) begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else if (in_name == NAME_DOT || in_name == NAME_DOTDOT) begin
            found_nxt = 1'b1;
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (probe_hit) begin
          found_nxt = 1'b1;
          fino_nxt  = slot_ino_r[idx_r[SLOT_W-1:0]];
          state_nxt = S_DECIDE;
        end else if (idx_r == SCAN_W'(USER_SLOTS - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + SCAN_W'(1);
        end
      end

      S_DECIDE: begin
        idx_nxt = '0;
        if (cmd_r == CMD_WRITE) begin
          if (!found_r) begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else if (kind_r[fino_r] != KIND_FILE) begin
            stat_nxt  = ST_NOT_FILE;
            state_nxt = S_DONE;
          end else if (has_blk_r[fino_r]) begin
            blk_nxt   = iblk_r[fino_r];
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_BLOCK;
          end
        end else if (found_r) begin
          stat_nxt  = ST_EXISTS;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INODE;
        end
      end

      S_INODE: begin
        if (probe_hit) begin
          ni_nxt    = idx_r[INO_W-1:0];
          idx_nxt   = '0;
          state_nxt = (cmd_r == CMD_MKDIR) ? S_BLOCK : S_SLOT;
        end else if (idx_r == SCAN_W'(INODE_COUNT - 1)) begin
          stat_nxt  = ST_NO_INODE;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + SCAN_W'(1);
        end
      end

      S_BLOCK: begin
        if (probe_hit) begin
          blk_nxt   = idx_r[BLK_W-1:0];
          idx_nxt   = '0;
          state_nxt = (cmd_r == CMD_WRITE) ? S_COMMIT : S_SLOT;
        end else if (idx_r == SCAN_W'(BLOCK_COUNT - 1)) begin
          stat_nxt  = ST_NO_BLOCK;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + SCAN_W'(1);
        end
      end

      S_SLOT: begin
        if (probe_hit) begin
          sl_nxt    = idx_r[SLOT_W-1:0];
          state_nxt = S_COMMIT;
        end else if (idx_r == SCAN_W'(USER_SLOTS - 1)) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + SCAN_W'(1);
        end
      end

      S_COMMIT: begin
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_CREATE: begin
            inode_busy_nxt[ni_r] = 1'b1;
            kind_nxt[ni_r]       = KIND_FILE;
            has_blk_nxt[ni_r]    = 1'b0;
            iblk_nxt[ni_r]       = '0;
            slot_name_nxt[sl_r]  = name_r;
            slot_ino_nxt[sl_r]   = ni_r;
            file_total_nxt       = sat_inc(file_total_r);
            res_ino_nxt          = ni_r;
          end
          CMD_MKDIR: begin
            inode_busy_nxt[ni_r] = 1'b1;
            kind_nxt[ni_r]       = KIND_DIR;
            has_blk_nxt[ni_r]    = 1'b1;
            iblk_nxt[ni_r]       = blk_r;
            block_busy_nxt[blk_r] = 1'b1;
            slot_name_nxt[sl_r]  = name_r;
            slot_ino_nxt[sl_r]   = ni_r;
            root_links_nxt       = sat_inc(root_links_r);
            dir_total_nxt        = sat_inc(dir_total_r);
            res_ino_nxt          = ni_r;
          end
          CMD_WRITE: begin
            block_busy_nxt[blk_r] = 1'b1;
            iblk_nxt[fino_r]      = blk_r;
            has_blk_nxt[fino_r]   = 1'b1;
            res_ino_nxt           = fino_r;
          end
          default: begin
            stat_nxt = ST_NOT_FOUND;
          end
        endcase
      end

      S_DONE: begin
        // Hold the finished result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_nxt.status       = stat_r;
          out_nxt.inode_number = res_ino_r;
          out_nxt.files_made   = file_total_r;
          out_nxt.dirs_made    = dir_total_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      inode_busy_r <= INODE_COUNT'(1);
      // Inode zero is the root directory, every other kind is free
      kind_r       <= (2 * INODE_COUNT)'(KIND_DIR);
      iblk_r       <= '0;
      has_blk_r    <= INODE_COUNT'(1);
      block_busy_r <= BLOCK_COUNT'(1);
      slot_name_r  <= '0;
      slot_ino_r   <= '0;
      root_links_r <= CNT_W'(2);
      file_total_r <= '0;
      dir_total_r  <= CNT_W'(1);
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      inode_busy_r <= inode_busy_nxt;
      kind_r       <= kind_nxt;
      iblk_r       <= iblk_nxt;
      has_blk_r    <= has_blk_nxt;
      block_busy_r <= block_busy_nxt;
      slot_name_r  <= slot_name_nxt;
      slot_ino_r   <= slot_ino_nxt;
      root_links_r <= root_links_nxt;
      file_total_r <= file_total_nxt;
      dir_total_r  <= dir_total_nxt;
    end
    cmd_r     <= cmd_nxt;
    name_r    <= name_nxt;
    byte_r    <= byte_nxt;
    idx_r     <= idx_nxt;
    found_r   <= found_nxt;
    fino_r    <= fino_nxt;
    ni_r      <= ni_nxt;
    blk_r     <= blk_nxt;
    sl_r      <= sl_nxt;
    stat_r    <= stat_nxt;
    res_ino_r <= res_ino_nxt;
    out_r     <= out_nxt;
  end

  // File data store, one byte per block
  assign mem_we = (state_r == S_COMMIT) && (cmd_r == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stored_mem[blk_r] <= byte_r;
    end
  end

  `IDA_ASSERT_IMPL(a_root_held, clk, rst_n, 1'b1, inode_busy_r[0] && block_busy_r[0],
                   "root inode or block released")
  `IDA_ASSERT_IMPL(a_inode_count, clk, rst_n, 1'b1,
                   $countones(inode_busy_r) == int'(file_total_r) + int'(dir_total_r),
                   "inode bitmap disagrees with object counters")
  `IDA_ASSERT_IMPL(a_dir_blocks, clk, rst_n, 1'b1,
                   $countones(block_busy_r) >= int'(dir_total_r),
                   "fewer blocks in use than directories")
  `IDA_ASSERT_IMPL(a_slot_live, clk, rst_n, slot_name_r[0] != '0,
                   inode_busy_r[slot_ino_r[0]],
                   "occupied slot points at a free inode")
  `IDA_ASSERT_IMPL(a_out_load, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE),
                   "result loaded outside the result state")

endmodule
